@@ rtl/core/dapg_pkg.sv @@
// shared types and constants of the dram aware power governor
package dapg_pkg;

  localparam int RegionW   = 6;
  localparam int CountW    = 8;
  localparam int PowerW    = 22;
  localparam int BudgetW   = 24;
  localparam int LimitW    = 23;
  localparam int TotalW    = 23;
  localparam int LTotalW   = 24;
  localparam int TargetW   = 24;
  localparam int GuardW    = 16;
  localparam int BandW     = GuardW + LTotalW;
  localparam int CmpW      = BandW + 1;
  localparam int CfgAddrW  = 2;
  localparam int CfgDataW  = 16;
  localparam int InDataW   = 88;
  localparam int OutDataW  = 56;
  localparam int MaxDomains = 2;

  localparam int NumDomainsDef = 2;
  localparam int NumRegionsDef = 64;

  localparam logic [LimitW-1:0]  LimitMax        = 23'h7FFFFF;
  localparam logic [CountW-1:0]  CountMax        = 8'hFF;
  localparam logic [CountW-1:0]  MinConvergedRst = 8'd5;
  localparam logic [CountW-1:0]  MinSamplesRst   = 8'd5;
  localparam logic [GuardW-1:0]  GuardBandRst    = 16'd1311;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_MIN_CONVERGED = 2'd0,
    CFG_MIN_SAMPLES   = 2'd1,
    CFG_GUARD_BAND    = 2'd2
  } cfg_addr_e;

  typedef enum logic {
    REQ_SAMPLE = 1'b0,
    REQ_BUDGET = 1'b1
  } req_type_e;

  typedef struct packed {
    req_type_e                          req_type;
    logic [RegionW-1:0]                 region;
    logic [CountW-1:0]                  sample_count;
    logic [MaxDomains-1:0][PowerW-1:0]  power;
    logic                               power_valid;
    logic [BudgetW-1:0]                 node_budget;
  } item_t;

  typedef struct packed {
    logic                converged;
    logic [CountW-1:0]   quiet;
  } region_entry_t;

  typedef struct packed {
    logic                load;
    logic                trig;
    logic [LimitW-1:0]   split;
  } lane_ctrl_t;

endpackage

@@ rtl/core/dapg_ram.sv @@
// generic single write port ram with registered read
module dapg_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/dapg_lane.sv @@
// one power domain lane: domain limit register and target subtraction
module dapg_lane
  import dapg_pkg::*;
(
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  lane_ctrl_t                 ctrl_i,
  input  logic [PowerW-1:0]          power_i,
  output logic [LimitW-1:0]          limit_o,
  output logic signed [TargetW-1:0]  target_o
);

  logic [LimitW-1:0]         limit_q, limit_d;
  logic signed [TargetW-1:0] diff;

  always_comb begin
    limit_d = ctrl_i.load ? ctrl_i.split : limit_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign diff     = $signed({1'b0, limit_q}) - $signed({2'b00, power_i});
  assign target_o = ctrl_i.trig ? diff : '0;
  assign limit_o  = limit_q;

endmodule

@@ rtl/core/dram_aware_power_governor.sv @@
// top level of the dram aware power governor
//
// usage: requests enter on the s_axis channel, tuser selects a power sample (0) or a
// node budget (1). each request gives exactly one result on the m_axis channel, in order.
// a budget that differs from the last one splits evenly over the domain lanes and clears
// all region state; an in-range sample with enough energy samples and valid power is
// checked against the dram reference and guard band and may emit new per-domain targets.
// flow: the taken request and its region table read are registered at the accepting edge,
// then evaluation writes the output register once the previous result has been taken.
// throughput: one request per cycle while results are taken, set by the read-modify-write of
// the region table with write forwarding.
// configuration: cfg writes are always ready and should be issued while the block is idle.
// reset: limits, budget, reference and all region flags and counters clear at once through
// per-region valid bits, no clearing pass; registers return to their reset values.
// stall: when m_axis_tready is low the result holds, one more request is taken into the
// evaluation stage, then s_axis_tready drops until the result is taken.
module dram_aware_power_governor
  import dapg_pkg::*;
#(
  parameter int NUM_DOMAINS = NumDomainsDef,
  parameter int NUM_REGIONS = NumRegionsDef
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // region, sample_count, dram_power_0, dram_power_1, power_valid, node_budget, zero pad
  input  logic [InDataW-1:0]   s_axis_tdata,
  // req_type
  input  logic [0:0]           s_axis_tuser,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // target_0, target_1, target_updated, region_converged, budget_accepted, zero pad
  output logic [OutDataW-1:0]  m_axis_tdata,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CfgAddrW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0]  cfg_data_i
);

  localparam int RegDepth = (NUM_REGIONS < (1 << RegionW)) ? NUM_REGIONS : (1 << RegionW);
  localparam int IdxW     = $clog2(RegDepth);
  localparam int EntryW   = $bits(region_entry_t);

  item_t                 s_item;
  item_t                 p_q;
  logic                  p_valid_q, p_valid_d;
  logic                  p_go, s_go;

  logic [CountW-1:0]     min_conv_q, min_samp_q;
  logic [GuardW-1:0]     guard_q;
  logic [BudgetW-1:0]    last_q;
  logic                  seen_q;
  logic [TotalW-1:0]     ref_q;
  logic                  ref_valid_q;
  logic [BandW-1:0]      band_q;
  logic [RegDepth-1:0]   vld_q;
  logic                  hit_q;
  region_entry_t         fwd_q;

  logic                  out_valid_q;
  logic [OutDataW-1:0]   out_q;

  logic [IdxW-1:0]       p_idx, s_idx;
  logic [EntryW-1:0]     ram_rdata;
  region_entry_t         ent, ent_new;
  logic                  ent_flag;
  logic [CountW-1:0]     ent_cnt, cnt_inc;
  logic                  in_range, bud_take, eval, trig, wr_en;
  logic [BudgetW-1:0]    quot;
  logic [LimitW-1:0]     split;
  logic [TotalW-1:0]     total;
  logic [LTotalW-1:0]    ltotal;
  logic [CmpW-1:0]       p16, r16, band_x;
  logic                  conv_out;
  lane_ctrl_t            lane_ctrl;
  logic [LimitW-1:0]         lane_limit  [MaxDomains];
  logic signed [TargetW-1:0] lane_target [MaxDomains];
  logic [PowerW-1:0]         lane_power  [MaxDomains];

  // request unpacking
  assign s_item.req_type     = req_type_e'(s_axis_tuser[0]);
  assign s_item.region       = s_axis_tdata[5:0];
  assign s_item.sample_count = s_axis_tdata[13:6];
  assign s_item.power[0]     = s_axis_tdata[35:14];
  assign s_item.power[1]     = s_axis_tdata[57:36];
  assign s_item.power_valid  = s_axis_tdata[58];
  assign s_item.node_budget  = s_axis_tdata[82:59];

  assign p_go          = p_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !p_valid_q || p_go;
  assign s_go          = s_axis_tvalid && s_axis_tready;
  assign p_valid_d     = s_go ? 1'b1 : (p_go ? 1'b0 : p_valid_q);

  assign s_idx = s_item.region[IdxW-1:0];
  assign p_idx = p_q.region[IdxW-1:0];

  dapg_ram #(
    .WIDTH (EntryW),
    .DEPTH (RegDepth)
  ) u_region_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (p_idx),
    .wdata_i (ent_new),
    .re_i    (s_go),
    .raddr_i (s_idx),
    .rdata_o (ram_rdata)
  );

  // domain lanes
  for (genvar d = 0; d < MaxDomains; d++) begin : g_lane
    if (d < NUM_DOMAINS) begin : g_used
      assign lane_power[d] = p_q.power[d];
      dapg_lane u_lane (
        .clk_i    (clk_i),
        .rst_ni   (rst_ni),
        .ctrl_i   (lane_ctrl),
        .power_i  (lane_power[d]),
        .limit_o  (lane_limit[d]),
        .target_o (lane_target[d])
      );
    end else begin : g_unused
      assign lane_power[d]  = '0;
      assign lane_limit[d]  = '0;
      assign lane_target[d] = '0;
    end
  end

  // merge of lane totals
  always_comb begin
    total  = '0;
    ltotal = '0;
    for (int d = 0; d < MaxDomains; d++) begin
      total  = total + TotalW'(lane_power[d]);
      ltotal = ltotal + LTotalW'(lane_limit[d]);
    end
  end

  always_comb begin
    quot     = BudgetW'(32'(p_q.node_budget) / NUM_DOMAINS);
    split    = (quot > BudgetW'(LimitMax)) ? LimitMax : quot[LimitW-1:0];
    in_range = 32'(p_q.region) < NUM_REGIONS;
    bud_take = (p_q.req_type == REQ_BUDGET) && (!seen_q || (p_q.node_budget != last_q));
    eval     = (p_q.req_type == REQ_SAMPLE) && in_range && p_q.power_valid &&
               (p_q.sample_count >= min_samp_q);

    p16    = CmpW'({total, 16'h0000});
    r16    = CmpW'({ref_q, 16'h0000});
    band_x = CmpW'(band_q);
    trig   = !ref_valid_q || ((p16 + band_x) < r16) || (p16 > (r16 + band_x));

    ent      = hit_q ? fwd_q : region_entry_t'(ram_rdata);
    ent_flag = vld_q[p_idx] && ent.converged;
    ent_cnt  = vld_q[p_idx] ? ent.quiet : '0;
    cnt_inc  = (ent_cnt == CountMax) ? ent_cnt : ent_cnt + 8'd1;

    ent_new.converged = ent_flag;
    ent_new.quiet     = ent_cnt;
    if (!ent_flag) begin
      if (trig) begin
        ent_new.quiet = '0;
      end else if (cnt_inc >= min_conv_q) begin
        ent_new.converged = 1'b1;
        ent_new.quiet     = '0;
      end else begin
        ent_new.quiet = cnt_inc;
      end
    end

    wr_en = p_go && eval;

    lane_ctrl.load  = p_go && bud_take;
    lane_ctrl.trig  = eval && trig;
    lane_ctrl.split = split;

    if (!in_range || bud_take) begin
      conv_out = 1'b0;
    end else if (eval) begin
      conv_out = ent_new.converged;
    end else begin
      conv_out = ent_flag;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      min_conv_q  <= MinConvergedRst;
      min_samp_q  <= MinSamplesRst;
      guard_q     <= GuardBandRst;
      last_q      <= '0;
      seen_q      <= 1'b0;
      ref_q       <= '0;
      ref_valid_q <= 1'b0;
      band_q      <= '0;
      vld_q       <= '0;
      hit_q       <= 1'b0;
    end else begin
      p_valid_q <= p_valid_d;
      band_q    <= BandW'(guard_q) * BandW'(ltotal);
      // forwarding choice stays with the request while it waits in the evaluation stage
      if (s_go) begin
        hit_q <= wr_en && (s_idx == p_idx);
      end

      if (cfg_valid_i) begin
        unique case (cfg_addr_i)
          CFG_MIN_CONVERGED: min_conv_q <= cfg_data_i[CountW-1:0];
          CFG_MIN_SAMPLES:   min_samp_q <= cfg_data_i[CountW-1:0];
          CFG_GUARD_BAND:    guard_q    <= cfg_data_i;
          default: ;
        endcase
      end

      if (p_go) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      if (p_go && bud_take) begin
        last_q      <= p_q.node_budget;
        seen_q      <= 1'b1;
        ref_q       <= '0;
        ref_valid_q <= 1'b0;
        vld_q       <= '0;
      end else if (wr_en) begin
        vld_q[p_idx] <= 1'b1;
        if (trig) begin
          ref_q       <= total;
          ref_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_go) begin
      p_q <= s_item;
    end
    if (wr_en) begin
      fwd_q <= ent_new;
    end
    if (p_go) begin
      out_q <= {5'b00000, bud_take, conv_out, eval && trig,
                lane_target[1], lane_target[0]};
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

endmodule

@@ tb/sv/tb_top.sv @@
// testbench for the dram aware power governor: directed and random requests against a local model
`timescale 1ns / 1ps

module tb_top;
  import dapg_pkg::*;

  localparam int NumDomains   = NumDomainsDef;
  localparam int NumRegions   = NumRegionsDef;
  localparam int PowerMax     = (1 << PowerW) - 1;
  localparam int IdleLimit    = 4000;
  localparam int SettleCycles = 4;
  localparam int PhaseItems   = 250;

  typedef struct {
    logic [TargetW-1:0] target_0;
    logic [TargetW-1:0] target_1;
    logic               target_updated;
    logic               region_converged;
    logic               budget_accepted;
  } outcome_t;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic [0:0]          s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                cfg_valid_i;
  logic                cfg_ready_o;
  logic [CfgAddrW-1:0] cfg_addr_i;
  logic [CfgDataW-1:0] cfg_data_i;

  dram_aware_power_governor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i)
  );

  // governor state as predicted
  logic [LimitW-1:0]  lim_q [NumDomains];
  logic [BudgetW-1:0] last_budget_q;
  logic               budget_seen_q;
  logic [TotalW-1:0]  dram_ref_q;
  logic               ref_held_q;
  logic               conv_q [NumRegions];
  logic [CountW-1:0]  quiet_q [NumRegions];
  logic [CountW-1:0]  min_conv_q;
  logic [CountW-1:0]  min_samp_q;
  logic [GuardW-1:0]  guard_q;

  outcome_t          pending_outcomes [$];
  logic [PowerW-1:0] base_pwr [NumDomains];
  int                errors;
  int                n_requests;
  int                n_budget_changes;
  int                n_updates;
  int                n_convergences;
  int                burst_left;
  int                idle_cycles;
  int                rx_cycle;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic outcome_t governor_step(input item_t it);
    outcome_t    res;
    logic [63:0] split;
    logic [63:0] total;
    logic [63:0] ltotal;
    logic [63:0] band;
    logic [63:0] p16;
    logic [63:0] r16;
    logic [63:0] diff;
    logic        trig;
    int          d;
    int          r;
    res = '{default: '0};
    if (it.req_type == REQ_BUDGET) begin
      if (!budget_seen_q || it.node_budget != last_budget_q) begin
        split = 64'(it.node_budget) / NumDomains;
        if (split > 64'(LimitMax)) split = 64'(LimitMax);
        for (d = 0; d < NumDomains; d++) lim_q[d] = split[LimitW-1:0];
        for (r = 0; r < NumRegions; r++) begin
          conv_q[r] = 1'b0;
          quiet_q[r] = '0;
        end
        last_budget_q = it.node_budget;
        budget_seen_q = 1'b1;
        ref_held_q = 1'b0;
        dram_ref_q = '0;
        res.budget_accepted = 1'b1;
        n_budget_changes++;
      end
    end else if (it.region < NumRegions && it.sample_count >= min_samp_q && it.power_valid) begin
      total = '0;
      ltotal = '0;
      for (d = 0; d < NumDomains; d++) begin
        total += 64'(it.power[d]);
        ltotal += 64'(lim_q[d]);
      end
      if (!ref_held_q) begin
        trig = 1'b1;
      end else begin
        band = 64'(guard_q) * ltotal;
        p16 = total << 16;
        r16 = 64'(dram_ref_q) << 16;
        trig = (p16 + band < r16) || (p16 > r16 + band);
      end
      if (trig) begin
        dram_ref_q = total[TotalW-1:0];
        ref_held_q = 1'b1;
        diff = 64'(lim_q[0]) - 64'(it.power[0]);
        res.target_0 = diff[TargetW-1:0];
        diff = 64'(lim_q[1]) - 64'(it.power[1]);
        res.target_1 = diff[TargetW-1:0];
        res.target_updated = 1'b1;
        n_updates++;
      end
      if (!conv_q[it.region]) begin
        if (trig) begin
          quiet_q[it.region] = '0;
        end else begin
          if (quiet_q[it.region] != CountMax) quiet_q[it.region]++;
          if (quiet_q[it.region] >= min_conv_q) begin
            conv_q[it.region] = 1'b1;
            quiet_q[it.region] = '0;
            n_convergences++;
          end
        end
      end
    end
    res.region_converged = (it.region < NumRegions) ? conv_q[it.region] : 1'b0;
    return res;
  endfunction

  function automatic item_t make_sample(input int region, input int count, input int p0,
                                        input int p1, input logic valid);
    item_t it;
    it.req_type     = REQ_SAMPLE;
    it.region       = RegionW'(region);
    it.sample_count = CountW'(count);
    it.power[0]     = PowerW'(p0);
    it.power[1]     = PowerW'(p1);
    it.power_valid  = valid;
    it.node_budget  = BudgetW'($urandom);
    return it;
  endfunction

  function automatic item_t make_budget(input int budget);
    item_t it;
    it.req_type     = REQ_BUDGET;
    it.region       = RegionW'($urandom);
    it.sample_count = CountW'($urandom);
    it.power[0]     = PowerW'($urandom);
    it.power[1]     = PowerW'($urandom);
    it.power_valid  = 1'($urandom);
    it.node_budget  = BudgetW'(budget);
    return it;
  endfunction

  task automatic send_request(input item_t it);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.req_type;
    s_axis_tdata  <= InDataW'({it.node_budget, it.power_valid, it.power[1], it.power[0],
                               it.sample_count, it.region});
    do @(posedge clk_i); while (!s_axis_tready);
    pending_outcomes.push_back(governor_step(it));
    n_requests++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic apply_settings(input int mc, input int ms, input int gb);
    cfg_addr_e           addrs [3];
    logic [CfgDataW-1:0] vals [3];
    int                  i;
    addrs = '{CFG_MIN_CONVERGED, CFG_MIN_SAMPLES, CFG_GUARD_BAND};
    vals  = '{CfgDataW'(mc), CfgDataW'(ms), CfgDataW'(gb)};
    wait_drained();
    for (i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= addrs[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      case (addrs[i])
        CFG_MIN_CONVERGED: min_conv_q = vals[i][CountW-1:0];
        CFG_MIN_SAMPLES:   min_samp_q = vals[i][CountW-1:0];
        CFG_GUARD_BAND:    guard_q = vals[i][GuardW-1:0];
        default: ;
      endcase
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_random_traffic(input int count);
    item_t it;
    int    k;
    int    d;
    int    hot;
    int    jmax;
    int    pwr;
    hot = $urandom_range(0, NumRegions - 4);
    for (k = 0; k < count; k++) begin
      it = make_sample($urandom, $urandom, $urandom, $urandom, 1'($urandom));
      if ($urandom_range(0, 99) < 3) begin
        it.req_type = REQ_BUDGET;
        if ($urandom_range(0, 3) == 0 && budget_seen_q) begin
          it.node_budget = last_budget_q;
        end else if ($urandom_range(0, 3) == 0) begin
          it.node_budget = BudgetW'($urandom_range(0, 4000));
        end
        hot = $urandom_range(0, NumRegions - 4);
      end else if ($urandom_range(0, 99) < 85) begin
        // well-formed sample on a hot region near the working point
        it.region = RegionW'(hot + $urandom_range(0, 3));
        it.sample_count = CountW'($urandom_range(min_samp_q, CountMax));
        it.power_valid = ($urandom_range(0, 19) != 0);
        if ($urandom_range(0, 9) == 0) begin
          for (d = 0; d < NumDomains; d++) base_pwr[d] = PowerW'($urandom);
        end
        jmax = int'(lim_q[0] >> 6);
        for (d = 0; d < NumDomains; d++) begin
          pwr = int'(base_pwr[d]);
          if ($urandom_range(0, 2) != 0) pwr += int'($urandom_range(0, 2 * jmax)) - jmax;
          if (pwr < 0) pwr = 0;
          if (pwr > PowerMax) pwr = PowerMax;
          it.power[d] = PowerW'(pwr);
        end
      end
      send_request(it);
      if ($urandom_range(0, 199) == 0) wait_drained();
    end
  endtask

  task automatic test_reset_defaults();
    send_request(make_sample(0, MinSamplesRst, 0, 0, 1'b1));
    send_request(make_sample(0, MinSamplesRst, 0, 0, 1'b1));
    send_request(make_sample(0, CountMax, PowerMax, PowerMax, 1'b1));
  endtask

  task automatic test_budget_split();
    send_request(make_budget(0));
    send_request(make_budget(0));
    send_request(make_budget((1 << BudgetW) - 1));
    send_request(make_budget(1000001));
  endtask

  task automatic test_sample_filters();
    send_request(make_sample(3, MinSamplesRst - 1, 1000, 1000, 1'b1));
    send_request(make_sample(3, CountMax, 1000, 1000, 1'b0));
    send_request(make_sample(NumRegions - 1, CountMax, 300000, 200000, 1'b1));
  endtask

  task automatic test_convergence();
    int n;
    for (n = 0; n < MinConvergedRst; n++) send_request(make_sample(5, 10, 300000, 200000, 1'b1));
    // total at the upper edge of the band stays quiet
    send_request(make_sample(5, 10, 310000, 210000, 1'b1));
    send_request(make_sample(5, 10, 100000, 100000, 1'b1));
    send_request(make_budget(2000000));
  endtask

  task automatic test_loose_settings();
    apply_settings(1, 0, (1 << GuardW) - 1);
    run_random_traffic(PhaseItems);
  endtask

  task automatic test_strict_settings();
    apply_settings(CountMax, CountMax, 0);
    run_random_traffic(PhaseItems);
  endtask

  task automatic test_random_settings();
    apply_settings($urandom_range(1, CountMax), $urandom_range(0, 12), $urandom_range(0, 8000));
    run_random_traffic(PhaseItems);
  endtask

  task automatic test_default_settings();
    apply_settings(MinConvergedRst, MinSamplesRst, GuardBandRst);
    run_random_traffic(PhaseItems);
  endtask

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  // receiver stall pattern and result check
  always @(posedge clk_i) begin : check_results
    outcome_t want;
    rx_cycle++;
    case (rx_cycle[8:7])
      2'd0:    m_axis_tready <= 1'b1;
      2'd1:    m_axis_tready <= 1'($urandom);
      2'd2:    m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (rx_cycle[2:0] != 3'd0);
    endcase
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t ns: result with no request pending, expected none, actual %h",
                 $time, m_axis_tdata);
      end else begin
        want = pending_outcomes.pop_front();
        check_field("target_0", want.target_0, m_axis_tdata[TargetW-1:0]);
        check_field("target_1", want.target_1, m_axis_tdata[2*TargetW-1:TargetW]);
        check_field("target_updated", want.target_updated, m_axis_tdata[2*TargetW]);
        check_field("region_converged", want.region_converged, m_axis_tdata[2*TargetW+1]);
        check_field("budget_accepted", want.budget_accepted, m_axis_tdata[2*TargetW+2]);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               IdleLimit, pending_outcomes.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int r;
    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= REQ_SAMPLE;
    m_axis_tready <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cfg_addr_i    <= CFG_MIN_CONVERGED;
    cfg_data_i    <= '0;
    errors = 0;
    n_requests = 0;
    n_budget_changes = 0;
    n_updates = 0;
    n_convergences = 0;
    burst_left = 0;
    idle_cycles = 0;
    rx_cycle = 0;
    min_conv_q = MinConvergedRst;
    min_samp_q = MinSamplesRst;
    guard_q = GuardBandRst;
    last_budget_q = '0;
    budget_seen_q = 1'b0;
    dram_ref_q = '0;
    ref_held_q = 1'b0;
    for (r = 0; r < NumDomains; r++) begin
      lim_q[r] = '0;
      base_pwr[r] = PowerW'($urandom);
    end
    for (r = 0; r < NumRegions; r++) begin
      conv_q[r] = 1'b0;
      quiet_q[r] = '0;
    end
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_budget_split();
    test_sample_filters();
    test_convergence();
    test_loose_settings();
    test_strict_settings();
    test_random_settings();
    test_default_settings();
    wait_drained();
    $display("covered %0d requests under five register settings incl. both extremes, %0d budget changes",
             n_requests, n_budget_changes);
    $display("seen: %0d target updates, %0d regions marked converged, filtered samples, stalls",
             n_updates, n_convergences);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
